[rtl/sss_pkg.sv]
// Shared types, constants and table functions for the seeded step sequencer.
`default_nettype none

package sss_pkg;

    // Hash multipliers
    localparam logic [31:0] MUL_MIX1 = 32'h7feb352d;
    localparam logic [31:0] MUL_MIX2 = 32'h846ca68b;
    localparam logic [31:0] MUL_PAIR = 32'h9e3779b9;
    localparam logic [31:0] MUL_SEED = 32'h9e3779b1;

    localparam int STEP_W = 36;
    localparam int PC_W   = 5;
    localparam logic [PC_W-1:0] LAST_PC = 5'd26;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        SRC_SEED,
        SRC_ACC,
        SRC_ACC_X_T,
        SRC_TH,
        SRC_BAR,
        SRC_SIB,
        SRC_ZERO,
        SRC_BH
    } src_t;

    typedef enum logic [1:0] {
        SH_NONE,
        SH_15,
        SH_16
    } sh_t;

    typedef enum logic [1:0] {
        CM_MIX1,
        CM_MIX2,
        CM_PAIR,
        CM_SEED
    } cm_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_TH,
        DST_T,
        DST_BH,
        DST_SCALE,
        DST_PROG,
        DST_GROOVE,
        DST_ARPM,
        DST_FILL,
        DST_NH
    } dst_t;

    typedef struct packed {
        src_t       src;
        logic [4:0] addend;
        sh_t        sh;
        cm_t        cm;
        dst_t       dst;
    } uop_t;

    typedef struct packed {
        logic in_ready;
        logic run;
        logic load_out;
        uop_t uop;
    } ctl_t;

    // Result item, last field in the lowest bits
    typedef struct packed {
        logic [6:0] chord_note_fifth;
        logic [6:0] chord_note_third;
        logic [6:0] chord_note_root;
        logic       arp_accent;
        logic [6:0] arp_note;
        logic       arp_hit;
        logic [5:0] bass_note;
        logic       bass_on;
        logic [1:0] hat_level;
        logic       snare_hit;
        logic       kick_hit;
        logic [3:0] bar_step;
    } item_t;

    function automatic logic [31:0] fold16(input logic [31:0] x);
        return x ^ (x >> 16);
    endfunction

    // x mod 3 by summing base-4 digits (4 is 1 mod 3)
    function automatic logic [1:0] mod3_32(input logic [31:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [2:0] s3;
        s1 = '0;
        for (int i = 0; i < 16; i++)
        begin
            s1 = s1 + {4'b0, x[2*i +: 2]};
        end
        s2 = {2'b0, s1[1:0]} + {2'b0, s1[3:2]} + {2'b0, s1[5:4]};
        s3 = {1'b0, s2[1:0]} + {1'b0, s2[3:2]};
        return (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
    endfunction

    // x mod 6 from x mod 2 and x mod 3
    function automatic logic [2:0] mod6_32(input logic [31:0] x);
        logic [3:0] r;
        r = (x[0] ? 4'd3 : 4'd0) + {mod3_32(x), 2'b00};
        return (r >= 4'd6) ? 3'(r - 4'd6) : r[2:0];
    endfunction

    function automatic logic [5:0] root_note(input logic [2:0] idx);
        logic [5:0] n;
        unique case (idx)
            3'd0:    n = 6'd45;
            3'd1:    n = 6'd47;
            3'd2:    n = 6'd48;
            3'd3:    n = 6'd50;
            3'd4:    n = 6'd52;
            3'd5:    n = 6'd53;
            default: n = 6'd45;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] scale_step(input logic [1:0] scale, input logic [2:0] idx);
        logic [3:0] v;
        unique case (idx)
            3'd0:    v = 4'd0;
            3'd1:    v = 4'd2;
            3'd2:    v = scale[1] ? 4'd4 : 4'd3;
            3'd3:    v = (scale == 2'd3) ? 4'd6 : 4'd5;
            3'd4:    v = 4'd7;
            3'd5:    v = (scale == 2'd0) ? 4'd8 : 4'd9;
            3'd6:    v = scale[1] ? 4'd11 : 4'd10;
            default: v = 4'd0;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] prog_degree(input logic [2:0] prog, input logic [1:0] pos);
        logic [11:0] row;
        unique case (prog)
            3'd0:    row = {3'd4, 3'd3, 3'd5, 3'd0};
            3'd1:    row = {3'd4, 3'd5, 3'd3, 3'd0};
            3'd2:    row = {3'd4, 3'd0, 3'd3, 3'd5};
            3'd3:    row = {3'd3, 3'd5, 3'd4, 3'd0};
            3'd4:    row = {3'd4, 3'd3, 3'd6, 3'd0};
            3'd5:    row = {3'd4, 3'd5, 3'd2, 3'd0};
            default: row = {3'd4, 3'd3, 3'd5, 3'd0};
        endcase
        return row[3*pos +: 3];
    endfunction

    // Semitone offset of triad tone k (0 root, 1 third, 2 fifth) on degree deg
    function automatic logic [4:0] triad_tone(input logic [1:0] scale, input logic [2:0] deg,
                                              input logic [1:0] k);
        logic [3:0] d;
        d = {1'b0, deg} + {1'b0, k, 1'b0};
        return (d >= 4'd7) ? 5'(scale_step(scale, 3'(d - 4'd7)) + 5'd12)
                           : {1'b0, scale_step(scale, d[2:0])};
    endfunction

    function automatic uop_t mk(input src_t src, input logic [4:0] addend, input sh_t sh,
                                input cm_t cm, input dst_t dst);
        uop_t u;
        u.src    = src;
        u.addend = addend;
        u.sh     = sh;
        u.cm     = cm;
        u.dst    = dst;
        return u;
    endfunction

    // Microcode: each step issues one multiply and may store the finished
    // hash (fold16 of the accumulator) left by the step before.
    function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:    u = mk(SRC_SEED,    5'd0,  SH_NONE, CM_SEED, DST_NONE);
            5'd1:    u = mk(SRC_ACC,     5'd17, SH_16,   CM_MIX1, DST_NONE);
            5'd2:    u = mk(SRC_ACC,     5'd0,  SH_15,   CM_MIX2, DST_NONE);
            5'd3:    u = mk(SRC_BAR,     5'd0,  SH_16,   CM_MIX1, DST_TH);
            5'd4:    u = mk(SRC_ACC,     5'd0,  SH_15,   CM_MIX2, DST_NONE);
            5'd5:    u = mk(SRC_SEED,    5'd0,  SH_NONE, CM_PAIR, DST_T);
            5'd6:    u = mk(SRC_ACC_X_T, 5'd0,  SH_16,   CM_MIX1, DST_NONE);
            5'd7:    u = mk(SRC_ACC,     5'd0,  SH_15,   CM_MIX2, DST_NONE);
            5'd8:    u = mk(SRC_TH,      5'd1,  SH_16,   CM_MIX1, DST_BH);
            5'd9:    u = mk(SRC_ACC,     5'd0,  SH_15,   CM_MIX2, DST_NONE);
            5'd10:   u = mk(SRC_TH,      5'd2,  SH_16,   CM_MIX1, DST_SCALE);
            5'd11:   u = mk(SRC_ACC,     5'd0,  SH_15,   CM_MIX2, DST_NONE);
            5'd12:   u = mk(SRC_TH,      5'd4,  SH_16,   CM_MIX1, DST_PROG);
            5'd13:   u = mk(SRC_ACC,     5'd0,  SH_15,   CM_MIX2, DST_NONE);
            5'd14:   u = mk(SRC_TH,      5'd5,  SH_16,   CM_MIX1, DST_GROOVE);
            5'd15:   u = mk(SRC_ACC,     5'd0,  SH_15,   CM_MIX2, DST_NONE);
            5'd16:   u = mk(SRC_ZERO,    5'd7,  SH_16,   CM_MIX1, DST_ARPM);
            5'd17:   u = mk(SRC_ACC,     5'd0,  SH_15,   CM_MIX2, DST_NONE);
            5'd18:   u = mk(SRC_BH,      5'd0,  SH_NONE, CM_PAIR, DST_T);
            5'd19:   u = mk(SRC_ACC_X_T, 5'd0,  SH_16,   CM_MIX1, DST_NONE);
            5'd20:   u = mk(SRC_ACC,     5'd0,  SH_15,   CM_MIX2, DST_NONE);
            5'd21:   u = mk(SRC_SIB,     5'd31, SH_16,   CM_MIX1, DST_FILL);
            5'd22:   u = mk(SRC_ACC,     5'd0,  SH_15,   CM_MIX2, DST_NONE);
            5'd23:   u = mk(SRC_BH,      5'd0,  SH_NONE, CM_PAIR, DST_T);
            5'd24:   u = mk(SRC_ACC_X_T, 5'd0,  SH_16,   CM_MIX1, DST_NONE);
            5'd25:   u = mk(SRC_ACC,     5'd0,  SH_15,   CM_MIX2, DST_NONE);
            5'd26:   u = mk(SRC_ZERO,    5'd0,  SH_NONE, CM_SEED, DST_NH);
            default: u = mk(SRC_ZERO,    5'd0,  SH_NONE, CM_SEED, DST_NONE);
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[rtl/sss_hash_unit.sv]
// Shared hash datapath: operand select, add, xor-shift and one 32x32 multiply.
`default_nettype none

module sss_hash_unit
    import sss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        run,
    input  wire uop_t        uop,
    input  wire logic [31:0] seed,
    input  wire logic [31:0] th,
    input  wire logic [31:0] t,
    input  wire logic [31:0] bh,
    input  wire logic [31:0] bar,
    input  wire logic [3:0]  sib,
    output logic      [31:0] acc
);

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [31:0] src_val;
    logic [31:0] opnd;
    logic [31:0] shx;
    logic [31:0] mulc;

    always_comb
    begin
        unique case (uop.src)
            SRC_SEED:    src_val = seed;
            SRC_ACC:     src_val = acc_reg;
            SRC_ACC_X_T: src_val = acc_reg ^ t;
            SRC_TH:      src_val = th;
            SRC_BAR:     src_val = bar;
            SRC_SIB:     src_val = {28'b0, sib};
            SRC_ZERO:    src_val = '0;
            SRC_BH:      src_val = bh;
        endcase
        opnd = src_val + {27'b0, uop.addend};
        unique case (uop.sh)
            SH_15:   shx = opnd ^ (opnd >> 15);
            SH_16:   shx = opnd ^ (opnd >> 16);
            default: shx = opnd;
        endcase
        unique case (uop.cm)
            CM_MIX1: mulc = MUL_MIX1;
            CM_MIX2: mulc = MUL_MIX2;
            CM_PAIR: mulc = MUL_PAIR;
            CM_SEED: mulc = MUL_SEED;
        endcase
        acc_next = shx * mulc;
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[rtl/sss_ctrl.sv]
// Sequencer that walks the hash microcode for one tick and hands off the result.
`default_nettype none

module sss_ctrl
    import sss_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic out_free,
    output ctl_t      ctl
);

    state_t          state_reg;
    state_t          state_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                pc_next = '0;
                if (in_fire)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                pc_next = pc_reg + 1'b1;
                if (pc_reg == LAST_PC)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl.in_ready = (state_reg == ST_IDLE);
        ctl.run      = (state_reg == ST_RUN);
        ctl.load_out = (state_reg == ST_DONE) && out_free;
        ctl.uop      = uop_at(pc_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sss_events.sv]
// Event decode: drums, bass, arp and pad notes from the stored theme and bar hashes.
`default_nettype none

module sss_events
    import sss_pkg::*;
(
    input  wire logic [3:0]  sib,
    input  wire logic [1:0]  bar_pos,
    input  wire logic [2:0]  root_idx,
    input  wire logic [1:0]  scale,
    input  wire logic [2:0]  prog,
    input  wire logic [1:0]  groove,
    input  wire logic [1:0]  arp_style,
    input  wire logic        fill,
    input  wire logic [31:0] nh,
    input  wire logic        hats_sixteenths,
    output item_t            item
);

    logic [5:0] root;
    logic [2:0] deg;
    logic       kick;
    logic       bass;
    logic       arp;
    logic [1:0] bass_k;
    logic [7:0] bass_sum;
    logic [7:0] arp_sum;
    logic [7:0] c0_sum;
    logic [7:0] c1_sum;
    logic [7:0] c2_sum;
    logic [4:0] lift;

    always_comb
    begin
        root = root_note(root_idx);
        deg  = prog_degree(prog, bar_pos);

        unique case (groove)
            2'd0:    kick = (sib == 4'd0) || (sib == 4'd6) || (sib == 4'd8);
            2'd1:    kick = (sib == 4'd0) || (sib == 4'd8) || (sib == 4'd11);
            default: kick = (sib[1:0] == 2'd0);
        endcase
        if ((sib == 4'd14) && fill)
        begin
            kick = 1'b1;
        end

        if (groove == 2'd2)
        begin
            bass = (sib[1:0] == 2'd0) || (sib == 4'd14);
        end
        else
        begin
            bass = (sib == 4'd0) || (sib == 4'd3) || (sib == 4'd6) || (sib == 4'd8)
                || (sib == 4'd11);
        end
        bass_k   = ((sib == 4'd6) || (sib == 4'd11)) ? 2'd2 : 2'd0;
        bass_sum = {2'b0, root} - 8'd12 + {3'b0, triad_tone(scale, deg, bass_k)};

        unique case (arp_style)
            2'd0:    arp = !sib[0];
            2'd1:    arp = 1'b1;
            2'd2:    arp = (sib[1:0] != 2'd3);
            default: arp = sib[0];
        endcase
        lift    = (nh[6:5] == 2'd0) ? 5'd12 : 5'd0;
        arp_sum = {2'b0, root} + 8'd24 + {3'b0, triad_tone(scale, deg, mod3_32(nh))}
                + {3'b0, lift};

        c0_sum = {2'b0, root} + 8'd12 + {3'b0, triad_tone(scale, deg, 2'd0)};
        c1_sum = {2'b0, root} + 8'd12 + {3'b0, triad_tone(scale, deg, 2'd1)};
        c2_sum = {2'b0, root} + 8'd12 + {3'b0, triad_tone(scale, deg, 2'd2)};

        item.bar_step  = sib;
        item.kick_hit  = kick;
        item.snare_hit = (sib == 4'd4) || (sib == 4'd12);
        if (!sib[0] || hats_sixteenths)
        begin
            item.hat_level = (sib[1:0] == 2'd0) ? 2'd2 : 2'd1;
        end
        else
        begin
            item.hat_level = 2'd0;
        end
        item.bass_on          = bass;
        item.bass_note        = bass ? bass_sum[5:0] : 6'd0;
        item.arp_hit          = arp;
        item.arp_note         = arp ? arp_sum[6:0] : 7'd0;
        item.arp_accent       = arp && nh[9];
        item.chord_note_root  = c0_sum[6:0];
        item.chord_note_third = c1_sum[6:0];
        item.chord_note_fifth = c2_sum[6:0];
    end

endmodule

`default_nettype wire

[rtl/seeded_step_sequencer.sv]
// Top level of the seeded step sequencer: stream ports, APB registers, state and hash stores.
// Flow: an accepted tick runs 27 microcode steps on the shared 32x32 hash
//   multiplier, then its events are decoded and loaded into the output register.
// A new tick is taken only while idle (s_tready high), after the last result has been
//   loaded; the single shared multiplier sets this, since all multiplies of the
//   hash chain go through it in turn. A result still waiting at the end of the next
//   tick holds the sequencer until it is taken.
// Reset: rst_n clears the step counter, both registers, the sequencer and m_tvalid.
`default_nettype none

module seeded_step_sequencer
    import sss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // tick stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // step event stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] bar_step, [4] kick_hit, [5] snare_hit, [7:6] hat_level, [8] bass_on,
    // [14:9] bass_note, [15] arp_hit, [22:16] arp_note, [23] arp_accent,
    // [30:24] chord_note_root, [37:31] chord_note_third, [44:38] chord_note_fifth,
    // [47:45] zero
    output logic      [47:0] m_tdata,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    // Register index decode: theme_seed at byte 0, hats_sixteenths at byte 4
    localparam logic REG_SEED = 1'b0;
    localparam logic REG_HATS = 1'b1;

    ctl_t              ctl;
    logic              in_fire;
    logic              out_free;
    logic              cfg_write;
    logic [31:0]       acc;
    logic [31:0]       hash;
    item_t             item;

    logic [31:0]       seed_reg;
    logic              hats_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              m_tvalid_reg;
    logic [47:0]       m_tdata_reg;

    // Hash stores, written by the microcode
    logic [31:0]       th_reg;
    logic [31:0]       t_reg;
    logic [31:0]       bh_reg;
    logic [31:0]       nh_reg;
    logic [2:0]        root_idx_reg;
    logic [1:0]        scale_reg;
    logic [2:0]        prog_reg;
    logic [1:0]        groove_reg;
    logic [1:0]        arpm_reg;
    logic              fill_reg;

    assign in_fire   = s_tvalid && ctl.in_ready;
    // Output register can take a new item when empty or being drained this cycle
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_write = psel && penable && pwrite;
    assign hash      = fold16(acc);

    assign s_tready = ctl.in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_HATS) ? {31'b0, hats_reg} : seed_reg;

    sss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_free),
        .ctl      (ctl)
    );

    sss_hash_unit u_hash (
        .clk  (clk),
        .run  (ctl.run),
        .uop  (ctl.uop),
        .seed (seed_reg),
        .th   (th_reg),
        .t    (t_reg),
        .bh   (bh_reg),
        .bar  (step_reg[STEP_W-1:4]),
        .sib  (step_reg[3:0]),
        .acc  (acc)
    );

    sss_events u_events (
        .sib             (step_reg[3:0]),
        .bar_pos         (step_reg[5:4]),
        .root_idx        (root_idx_reg),
        .scale           (scale_reg),
        .prog            (prog_reg),
        .groove          (groove_reg),
        .arp_style       (arpm_reg),
        .fill            (fill_reg),
        .nh              (nh_reg),
        .hats_sixteenths (hats_reg),
        .item            (item)
    );

    // Restart zeroes the counter, otherwise advance one sixteenth (wraps at 2^36)
    assign step_next = s_tdata[0] ? '0 : step_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg     <= '0;
            hats_reg     <= 1'b0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (paddr[2] == REG_SEED)
                begin
                    seed_reg <= pwdata;
                end
                else
                begin
                    hats_reg <= pwdata[0];
                end
            end
            if (in_fire)
            begin
                step_reg <= step_next;
            end
            // Hold the result until taken; a load only comes when the slot is free
            if (ctl.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Store finished hashes, reduced to what the decode needs where possible
    always_ff @(posedge clk)
    begin
        if (ctl.run)
        begin
            unique case (ctl.uop.dst)
                DST_TH:
                begin
                    th_reg       <= hash;
                    root_idx_reg <= mod6_32(hash);
                end
                DST_T:      t_reg      <= hash;
                DST_BH:     bh_reg     <= hash;
                DST_SCALE:  scale_reg  <= hash[1:0];
                DST_PROG:   prog_reg   <= mod6_32(hash);
                DST_GROOVE: groove_reg <= mod3_32(hash);
                DST_ARPM:   arpm_reg   <= hash[1:0];
                DST_FILL:   fill_reg   <= (hash[1:0] == 2'd0);
                DST_NH:     nh_reg     <= hash;
                default:
                begin
                end
            endcase
        end
        if (ctl.load_out)
        begin
            m_tdata_reg <= {3'b0, item};
        end
    end

endmodule

`default_nettype wire

[tb/step_check_pkg.sv]
`timescale 1ns / 1ps
// Step event predictor and scoreboard class for the seeded step sequencer testbench.
package step_check_pkg;
    import sss_pkg::*;

    // Register indexes; the byte address is four times the index
    localparam int REG_THEME_SEED      = 0;
    localparam int REG_HATS_SIXTEENTHS = 1;

    typedef enum bit [1:0] {
        GROOVE_TWO_STEP,
        GROOVE_BROKEN,
        GROOVE_FOUR_FLOOR
    } groove_t;

    typedef enum bit [1:0] {
        ARP_EIGHTHS,
        ARP_SIXTEENTHS,
        ARP_SKIP_FOURTH,
        ARP_OFFBEATS
    } arp_style_t;

    localparam bit [5:0] TONIC [0:5] = '{6'd45, 6'd47, 6'd48, 6'd50, 6'd52, 6'd53};

    localparam bit [3:0] MODE_STEPS [0:3][0:6] = '{
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
        '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11}
    };

    localparam bit [2:0] CHORD_DEGREES [0:5][0:3] = '{
        '{3'd0, 3'd5, 3'd3, 3'd4},
        '{3'd0, 3'd3, 3'd5, 3'd4},
        '{3'd5, 3'd3, 3'd0, 3'd4},
        '{3'd0, 3'd4, 3'd5, 3'd3},
        '{3'd0, 3'd6, 3'd3, 3'd4},
        '{3'd0, 3'd2, 3'd5, 3'd4}
    };

    class step_event_board;
        bit [31:0] theme_seed;
        bit        hats_sixteenths;
        bit [35:0] step_count;
        item_t     pending_events[$];
        int        errors;

        function new();
            theme_seed      = '0;
            hats_sixteenths = 1'b0;
            step_count      = '0;
            errors          = 0;
        endfunction

        static function bit [31:0] mix32(bit [31:0] x);
            x = x ^ (x >> 16);
            x = x * 32'h7feb352d;
            x = x ^ (x >> 15);
            x = x * 32'h846ca68b;
            x = x ^ (x >> 16);
            return x;
        endfunction

        static function bit [31:0] hash_pair(bit [31:0] a, bit [31:0] b);
            bit [31:0] t;
            t = a * 32'h9e3779b9;
            return mix32(t ^ mix32(b));
        endfunction

        // semitone offset of triad tone k (root, third, fifth) on a scale degree
        static function bit [6:0] triad_offset(bit [1:0] mode, bit [2:0] deg, bit [1:0] k);
            int d;
            d = int'(deg) + 2 * int'(k);
            return 7'(int'(MODE_STEPS[mode][d % 7]) + 12 * (d / 7));
        endfunction

        function void write_reg(int idx, bit [31:0] value);
            if (idx == REG_THEME_SEED)
                theme_seed = value;
            else if (idx == REG_HATS_SIXTEENTHS)
                hats_sixteenths = value[0];
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        // Advance the step counter and queue the events of the new step
        function void note_tick(bit restart);
            bit [31:0]  th, bh, nh, bar;
            bit [5:0]   tonic;
            bit [1:0]   mode;
            bit [2:0]   prog, deg;
            groove_t    groove;
            arp_style_t arp_style;
            bit [3:0]   sib;
            bit         kick, bass, arp;
            item_t      ev;

            step_count = restart ? 36'd0 : step_count + 36'd1;

            th        = mix32(theme_seed * 32'd2654435761 + 32'd17);
            tonic     = TONIC[th % 6];
            mode      = 2'(mix32(th + 32'd1) % 4);
            prog      = 3'(mix32(th + 32'd2) % 6);
            groove    = groove_t'(2'(mix32(th + 32'd4) % 3));
            arp_style = arp_style_t'(2'(mix32(th + 32'd5) % 4));

            sib = step_count[3:0];
            bar = step_count[35:4];
            bh  = hash_pair(theme_seed, bar);
            deg = CHORD_DEGREES[prog][bar[1:0]];

            ev = '0;
            ev.bar_step = sib;

            case (groove)
                GROOVE_TWO_STEP: kick = (sib == 4'd0 || sib == 4'd6 || sib == 4'd8);
                GROOVE_BROKEN:   kick = (sib == 4'd0 || sib == 4'd8 || sib == 4'd11);
                default:         kick = (sib[1:0] == 2'd0);
            endcase
            nh = hash_pair(bh, 32'd7);
            if (sib == 4'd14 && nh[1:0] == 2'd0)
                kick = 1'b1;
            ev.kick_hit  = kick;
            ev.snare_hit = (sib == 4'd4 || sib == 4'd12);

            if (!sib[0] || hats_sixteenths)
                ev.hat_level = (sib[1:0] == 2'd0) ? 2'd2 : 2'd1;

            if (groove == GROOVE_FOUR_FLOOR)
                bass = (sib[1:0] == 2'd0) || sib == 4'd14;
            else
                bass = (sib == 4'd0 || sib == 4'd3 || sib == 4'd6 || sib == 4'd8
                        || sib == 4'd11);
            if (bass)
            begin
                ev.bass_on   = 1'b1;
                ev.bass_note = 6'(int'(tonic) - 12 + int'(triad_offset(mode, deg,
                                   (sib == 4'd6 || sib == 4'd11) ? 2'd2 : 2'd0)));
            end

            case (arp_style)
                ARP_EIGHTHS:     arp = !sib[0];
                ARP_SIXTEENTHS:  arp = 1'b1;
                ARP_SKIP_FOURTH: arp = (sib[1:0] != 2'd3);
                default:         arp = sib[0];
            endcase
            if (arp)
            begin
                nh = hash_pair(bh, 32'(sib) + 32'd31);
                ev.arp_hit    = 1'b1;
                ev.arp_note   = 7'(int'(tonic) + 24
                                   + int'(triad_offset(mode, deg, 2'(nh % 3)))
                                   + ((nh[6:5] == 2'd0) ? 12 : 0));
                ev.arp_accent = nh[9];
            end

            ev.chord_note_root  = 7'(int'(tonic) + 12 + int'(triad_offset(mode, deg, 2'd0)));
            ev.chord_note_third = 7'(int'(tonic) + 12 + int'(triad_offset(mode, deg, 2'd1)));
            ev.chord_note_fifth = 7'(int'(tonic) + 12 + int'(triad_offset(mode, deg, 2'd2)));

            pending_events.push_back(ev);
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one accepted step event with the oldest prediction
        function void check_event(logic [47:0] data);
            item_t got, want;
            got = data[44:0];
            if (pending_events.size() == 0)
            begin
                $display("%0t: step event %h with none expected", $time, data);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            cmp_field("bar_step", 32'(want.bar_step), 32'(got.bar_step));
            cmp_field("kick_hit", 32'(want.kick_hit), 32'(got.kick_hit));
            cmp_field("snare_hit", 32'(want.snare_hit), 32'(got.snare_hit));
            cmp_field("hat_level", 32'(want.hat_level), 32'(got.hat_level));
            cmp_field("bass_on", 32'(want.bass_on), 32'(got.bass_on));
            cmp_field("bass_note", 32'(want.bass_note), 32'(got.bass_note));
            cmp_field("arp_hit", 32'(want.arp_hit), 32'(got.arp_hit));
            cmp_field("arp_note", 32'(want.arp_note), 32'(got.arp_note));
            cmp_field("arp_accent", 32'(want.arp_accent), 32'(got.arp_accent));
            cmp_field("chord_note_root", 32'(want.chord_note_root),
                      32'(got.chord_note_root));
            cmp_field("chord_note_third", 32'(want.chord_note_third),
                      32'(got.chord_note_third));
            cmp_field("chord_note_fifth", 32'(want.chord_note_fifth),
                      32'(got.chord_note_fifth));
            cmp_field("pad bits", 32'd0, 32'(data[47:45]));
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top-level testbench for the seeded step sequencer: stimulus, idling, checks and verdict.
module tb_top;
    import sss_pkg::*;
    import step_check_pkg::*;

    // The run sends 309 to 629 ticks; even with long gaps and
    // stalls it stays well under a tenth of this.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 16;
    localparam int TAIL_CYCLES   = 40;
    localparam int PAUSE_PHASE   = 5;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;     // [0] restart, [7:1] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [3:0] bar_step, [4] kick_hit, [5] snare_hit, [7:6] hat_level, [8] bass_on,
    // [14:9] bass_note, [15] arp_hit, [22:16] arp_note, [23] arp_accent,
    // [30:24] chord_note_root, [37:31] chord_note_third, [44:38] chord_note_fifth,
    // [47:45] zero
    logic [47:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Idling odds in percent, set per phase
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int cycle_count  = 0;

    step_event_board board = new();

    seeded_step_sequencer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Count cycles and end the run if the block hangs
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Receiver: check each accepted step event against the oldest prediction,
    // then pick the ready level for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_event(m_tdata);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Pick the idling of both sides for the next phase
    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_gap_pct = 61; stall_pct = 0;  end
            2:       begin send_gap_pct = 0;  stall_pct = 61; end
            3:       begin send_gap_pct = 30; stall_pct = 30; end
            default: begin send_gap_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // Offer one tick item, hold it until accepted, and record its prediction.
    // Keep s_tvalid high between back-to-back items; drop it only for a gap.
    task automatic send_tick(input bit restart);
        int gap;
        gap = 0;
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
            gap = $urandom_range(1, 40);   // spread gaps over the whole run of a tick's job
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, restart};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_tick(restart);
    endtask

    // Stop sending and wait until every predicted step event has arrived
    task automatic drain_events();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup and access phase register write; the block is idle whenever this runs
    task automatic write_reg(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.write_reg(idx, value);
    endtask

    initial
    begin
        int          n_items;
        logic [31:0] seed;
        logic [31:0] hats_word;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lowest settings, every step position of a bar, a wrap into
        // the next bar, a restart mid-bar and two restarts in a row.
        write_reg(REG_THEME_SEED, 32'd0);
        write_reg(REG_HATS_SIXTEENTHS, 32'd0);
        send_tick(1'b1);
        repeat (17) send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_events();

        // Random phases: a fresh theme per phase, the step counter running on
        // across phases so later bars and all four chords of a progression
        // come up. The first phase sets every register bit high; hats words
        // carry random upper bits that the block must drop.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                seed      = 32'hffff_ffff;
                hats_word = 32'hffff_ffff;
            end
            else
            begin
                seed      = $urandom();
                hats_word = $urandom();
            end
            write_reg(REG_THEME_SEED, seed);
            write_reg(REG_HATS_SIXTEENTHS, hats_word);
            set_idling(ph % 4);

            n_items = $urandom_range(18, 38);
            for (int i = 0; i < n_items; i++)
            begin
                // hold off once mid-phase until the block has emptied out
                if (ph == PAUSE_PHASE && i == n_items / 2)
                    drain_events();
                send_tick($urandom_range(79) == 0);
            end
            drain_events();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
